[sv/ffba_pkg.sv]
// shared types and fixed constants of the first-fit block allocator
package ffba_pkg;

	// status codes of a result beat
	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_NOFIT   = 2'd1,
		ST_IGNORED = 2'd2
	} status_t;

	// operation codes of an input beat
	typedef enum logic {
		OP_ALLOC   = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	// width of the rounded request and of the unit demand
	localparam int NW = 17;
	// width of a byte total before saturation
	localparam int PW = 32;
	// width of the address fields on the ports
	localparam int ADDR_W = 12;

endpackage

[sv/ffba_mem.sv]
// block list memory: one write port, one registered read port
module ffba_mem #(
	parameter int AW = 12,
	parameter int DW = 25
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/ffba_div.sv]
// reciprocal-multiply divider by a fixed unit size
module ffba_div #(
	parameter int DIVISOR = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [ffba_pkg::NW-1:0] dividend,
	output logic                  done,
	output logic [ffba_pkg::NW-1:0] quotient
);

	localparam int SH = ffba_pkg::NW + $clog2(DIVISOR);
	localparam int MW = ffba_pkg::NW + 1;
	localparam logic [MW-1:0] RECIP =
		MW'(((longint'(1) << SH) + longint'(DIVISOR) - 1) / longint'(DIVISOR));

	logic [ffba_pkg::NW+MW-1:0] prod;
	logic [ffba_pkg::NW-1:0]    quo_q;
	logic                       done_q;

	// exact floor quotient from the scaled reciprocal
	assign prod = {{MW{1'b0}}, dividend} * {{ffba_pkg::NW{1'b0}}, RECIP};

	// quotient is valid from the cycle after start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else if (start) begin
			done_q <= 1'b1;
		end
	end

	// quotient register
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= ffba_pkg::NW'(prod >> SH);
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[sv/first_fit_block_allocator.sv]
// First-fit allocator over TOTAL_UNITS units of UNIT_BYTES bytes. One beat in,
// one result beat out. An allocate first rounds the request in a
// reciprocal-multiply divider, then walks the block list one header at a time
// through the list memory and writes back one or two headers. A release walks
// the list the same way, reads the successor header if there is one and
// writes one header if the block is busy. A new beat is taken only after the
// result beat of the last one is registered, which waits on m_tready, and the
// rate falls with fragmentation. The list memory needs no clearing pass.
module first_fit_block_allocator #(
	parameter int TOTAL_UNITS = 4096,
	parameter int UNIT_BYTES  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// operation, request_bytes, release_address, zero pad
	input  logic [31:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status, block_address, free_bytes, used_bytes, zero pad
	output logic [47:0] m_tdata
);

	localparam int AW = $clog2(TOTAL_UNITS);
	localparam int DW = 2 * AW + 1;
	localparam int HW = (AW > ffba_pkg::ADDR_W) ? AW : ffba_pkg::ADDR_W;
	localparam int NW = ffba_pkg::NW;
	localparam int PW = ffba_pkg::PW;
	localparam logic [DW-1:0] RESET_WORD = {1'b0, AW'(TOTAL_UNITS - 1), AW'(0)};

	typedef enum logic [10:0] {
		S_IDLE = 11'b000_0000_0001,
		S_DIV  = 11'b000_0000_0010,
		S_ARD  = 11'b000_0000_0100,
		S_ACHK = 11'b000_0000_1000,
		S_AWR2 = 11'b000_0001_0000,
		S_RRD  = 11'b000_0010_0000,
		S_RCHK = 11'b000_0100_0000,
		S_NRD  = 11'b000_1000_0000,
		S_NCHK = 11'b001_0000_0000,
		S_RMRG = 11'b010_0000_0000,
		S_DONE = 11'b100_0000_0000
	} state_t;

	state_t              state_q;
	logic [ffba_pkg::ADDR_W-1:0] rel_q;
	logic [NW-1:0]       need_q;
	logic [AW-1:0]       cur_q;
	logic [AW-1:0]       prev_q;
	logic                has_prev_q;
	logic [DW-1:0]       prevw_q;
	logic [AW-1:0]       tgt_q;
	logic [AW-1:0]       tlink_q;
	logic [AW-1:0]       hunits_q;
	logic [AW-1:0]       mlink_q;
	logic [AW-1:0]       munits_q;
	logic [AW-1:0]       free_q;
	logic [AW-1:0]       used_q;
	ffba_pkg::status_t   status_q;
	logic [ffba_pkg::ADDR_W-1:0] addr_q;
	logic                w0v_q;
	logic                rd_zero_s1;
	logic                out_valid_q;
	logic [47:0]         out_data_q;

	logic                div_start;
	logic                div_done;
	logic [NW-1:0]       div_q;
	logic [NW-1:0]       dividend;

	logic                we;
	logic [AW-1:0]       waddr;
	logic [DW-1:0]       wdata;
	logic [AW-1:0]       raddr;
	logic [DW-1:0]       rdata_raw;
	logic [DW-1:0]       rdata;

	logic [AW-1:0]       w_link;
	logic [AW-1:0]       w_units;
	logic                w_busy;
	logic                fit;
	logic                exact;
	logic [AW-1:0]       need_a;
	logic [AW-1:0]       target;
	logic                is_hdr;
	logic                merge_prev;
	logic [PW-1:0]       free_prod;
	logic [PW-1:0]       used_prod;
	logic [15:0]         free_b;
	logic [15:0]         used_b;
	logic                accept_in;

	assign accept_in = s_tvalid && s_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign dividend  = NW'(s_tdata[16:1]) + NW'(UNIT_BYTES - 1);
	assign div_start = accept_in && (s_tdata[0] == ffba_pkg::OP_ALLOC);

	ffba_div #(.DIVISOR(UNIT_BYTES)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.done     (div_done),
		.quotient (div_q)
	);

	ffba_mem #(.AW(AW), .DW(DW)) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata_raw)
	);

	// head entry reads its reset value until first written
	assign rdata   = (rd_zero_s1 && !w0v_q) ? RESET_WORD : rdata_raw;
	assign w_link  = rdata[AW-1:0];
	assign w_units = rdata[2*AW-1:AW];
	assign w_busy  = rdata[2*AW];

	// fit test and split point
	always_comb begin
		fit        = !w_busy && ({{(NW-AW){1'b0}}, w_units} >= need_q);
		exact      = {{(NW-AW){1'b0}}, w_units} == need_q;
		need_a     = need_q[AW-1:0];
		target     = cur_q + w_units - need_a;
		is_hdr     = HW'(cur_q) == HW'(rel_q - 1'b1);
		merge_prev = has_prev_q && !prevw_q[2*AW];
	end

	// memory port control
	always_comb begin
		raddr = cur_q;
		we    = 1'b0;
		waddr = cur_q;
		wdata = rdata;
		case (state_q)
			S_NRD: begin
				raddr = mlink_q;
			end
			S_ACHK: begin
				if (fit) begin
					we = 1'b1;
					if (exact) begin
						wdata = {1'b1, w_units, w_link};
					end else begin
						wdata = {1'b0, w_units - need_a, target};
					end
				end
			end
			S_AWR2: begin
				we    = 1'b1;
				waddr = tgt_q;
				wdata = {1'b1, need_a, tlink_q};
			end
			S_RMRG: begin
				we = 1'b1;
				if (merge_prev) begin
					waddr = prev_q;
					wdata = {1'b0, prevw_q[2*AW-1:AW] + munits_q, mlink_q};
				end else begin
					waddr = cur_q;
					wdata = {1'b0, munits_q, mlink_q};
				end
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// byte totals with saturation
	always_comb begin
		free_prod = PW'(free_q) * PW'(UNIT_BYTES);
		used_prod = PW'(used_q) * PW'(UNIT_BYTES);
		free_b    = (free_prod > PW'(16'hFFFF)) ? 16'hFFFF : free_prod[15:0];
		used_b    = (used_prod > PW'(16'hFFFF)) ? 16'hFFFF : used_prod[15:0];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			free_q      <= AW'(TOTAL_UNITS - 1);
			used_q      <= '0;
			w0v_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (we && waddr == '0) begin
				w0v_q <= 1'b1;
			end
			if (out_valid_q && m_tready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept_in) begin
						if (s_tdata[0] == ffba_pkg::OP_ALLOC) begin
							state_q <= S_DIV;
						end else if (s_tdata[28:17] == '0) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_RRD;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_ARD;
					end
				end
				S_ARD: begin
					state_q <= S_ACHK;
				end
				S_ACHK: begin
					if (fit) begin
						free_q  <= free_q - need_a;
						used_q  <= used_q + need_a;
						state_q <= exact ? S_DONE : S_AWR2;
					end else if (w_link == '0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_ARD;
					end
				end
				S_AWR2: begin
					state_q <= S_DONE;
				end
				S_RRD: begin
					state_q <= S_RCHK;
				end
				S_RCHK: begin
					if (is_hdr) begin
						if (!w_busy) begin
							state_q <= S_DONE;
						end else if (w_link != '0) begin
							state_q <= S_NRD;
						end else begin
							state_q <= S_RMRG;
						end
					end else if (w_link == '0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_RRD;
					end
				end
				S_NRD: begin
					state_q <= S_NCHK;
				end
				S_NCHK: begin
					state_q <= S_RMRG;
				end
				S_RMRG: begin
					used_q  <= used_q - hunits_q;
					free_q  <= free_q + hunits_q;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// walk and result registers
	always_ff @(posedge clk) begin
		rd_zero_s1 <= (raddr == '0);
		case (state_q)
			S_IDLE: begin
				rel_q      <= s_tdata[28:17];
				cur_q      <= '0;
				has_prev_q <= 1'b0;
				status_q   <= ffba_pkg::ST_IGNORED;
				addr_q     <= '0;
			end
			S_DIV: begin
				need_q <= div_q + 1'b1;
			end
			S_ACHK: begin
				if (fit) begin
					status_q <= ffba_pkg::ST_DONE;
					addr_q   <= exact ? HW'(cur_q + 1'b1) : HW'(target + 1'b1);
					tgt_q    <= target;
					tlink_q  <= w_link;
				end else if (w_link == '0) begin
					status_q <= ffba_pkg::ST_NOFIT;
				end else begin
					cur_q <= w_link;
				end
			end
			S_RCHK: begin
				if (is_hdr) begin
					hunits_q <= w_units;
					munits_q <= w_units;
					mlink_q  <= w_link;
				end else begin
					prev_q     <= cur_q;
					prevw_q    <= rdata;
					has_prev_q <= 1'b1;
					cur_q      <= w_link;
				end
			end
			S_NCHK: begin
				if (!w_busy) begin
					munits_q <= munits_q + w_units;
					mlink_q  <= w_link;
				end
			end
			S_RMRG: begin
				status_q <= ffba_pkg::ST_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || m_tready) begin
					out_data_q <= {2'b00, used_b, free_b, addr_q, status_q};
				end
			end
			default: begin
				addr_q <= addr_q;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

[sv/ffba_checker.sv]
// port-level checks of the first-fit block allocator
module ffba_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [31:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata
);

	// a held result beat keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// status is one of the three defined codes
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] == ffba_pkg::ST_DONE ||
			m_tdata[1:0] == ffba_pkg::ST_NOFIT ||
			m_tdata[1:0] == ffba_pkg::ST_IGNORED)
		else $error("undefined status code");

	// a failed or ignored request returns no address
	a_addr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] != ffba_pkg::ST_DONE |-> m_tdata[13:2] == 12'd0)
		else $error("address on failed request");

	// one request in flight at a time
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second beat taken while busy");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (.*);

[dv/tb_top.sv]
// self-checking testbench of the first-fit block allocator
module tb_top;

	localparam int HEAP_UNITS = 4096;
	localparam int UNIT_SZ    = 16;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;

	int send_idle;
	int recv_idle;
	bit failed;
	int n_left;

	typedef struct packed {
		ffba_pkg::status_t status;
		logic [11:0] addr;
		logic [15:0] free_b;
		logic [15:0] used_b;
	} heap_result_t;

	// heap shadow and queue of expected result beats
	class heap_scoreboard;
		int unsigned nxt[HEAP_UNITS];
		int unsigned units[HEAP_UNITS];
		bit busy[HEAP_UNITS];
		int unsigned free_u;
		int unsigned used_u;
		heap_result_t pending[$];
		int unsigned live[$];

		function new();
			foreach (nxt[i]) begin
				nxt[i] = 0;
				units[i] = 0;
				busy[i] = 0;
			end
			units[0] = HEAP_UNITS - 1;
			free_u = HEAP_UNITS - 1;
			used_u = 0;
		endfunction

		function logic [15:0] sat_bytes(int unsigned u);
			longint unsigned b;
			b = longint'(u) * UNIT_SZ;
			return (b > 65535) ? 16'hffff : b[15:0];
		endfunction

		function ffba_pkg::status_t alloc_blk(int unsigned req, output int unsigned addr);
			int unsigned need, cur, tgt;
			need = (req + UNIT_SZ - 1) / UNIT_SZ + 1;
			cur = 0;
			addr = 0;
			for (int s = 0; s < HEAP_UNITS; s++) begin
				if (!busy[cur] && units[cur] >= need) begin
					if (units[cur] == need) begin
						busy[cur] = 1;
						tgt = cur;
					end else begin
						tgt = cur + units[cur] - need;
						if (tgt >= HEAP_UNITS) return ffba_pkg::ST_NOFIT;
						units[tgt] = need;
						nxt[tgt] = nxt[cur];
						busy[tgt] = 1;
						units[cur] -= need;
						nxt[cur] = tgt;
					end
					free_u -= need;
					used_u += need;
					addr = tgt + 1;
					live.push_back(addr);
					return ffba_pkg::ST_DONE;
				end
				cur = nxt[cur];
				if (cur == 0 || cur >= HEAP_UNITS) break;
			end
			return ffba_pkg::ST_NOFIT;
		endfunction

		function ffba_pkg::status_t release_blk(int unsigned addr);
			int unsigned hdr, cur, prv, nx;
			bit has_prv, found;
			if (addr == 0) return ffba_pkg::ST_IGNORED;
			hdr = addr - 1;
			cur = 0;
			prv = 0;
			has_prv = 0;
			found = 0;
			for (int s = 0; s < HEAP_UNITS; s++) begin
				if (cur == hdr) begin
					found = 1;
					break;
				end
				prv = cur;
				has_prv = 1;
				cur = nxt[cur];
				if (cur == 0 || cur >= HEAP_UNITS) break;
			end
			if (!found || !busy[hdr]) return ffba_pkg::ST_IGNORED;
			used_u -= units[hdr];
			free_u += units[hdr];
			nx = nxt[hdr];
			// merge with a free successor, then with a free predecessor
			if (nx != 0 && nx < HEAP_UNITS && !busy[nx]) begin
				units[hdr] += units[nx];
				nxt[hdr] = nxt[nx];
			end
			if (has_prv && !busy[prv]) begin
				units[prv] += units[hdr];
				nxt[prv] = nxt[hdr];
			end else begin
				busy[hdr] = 0;
			end
			foreach (live[i]) if (live[i] == addr) begin
				live.delete(i);
				break;
			end
			return ffba_pkg::ST_DONE;
		endfunction

		// accepted input beat: predict its result
		function void note_request(logic [31:0] d);
			heap_result_t r;
			int unsigned a;
			a = 0;
			if (ffba_pkg::op_t'(d[0]) == ffba_pkg::OP_ALLOC) begin
				r.status = alloc_blk(32'(d[16:1]), a);
			end else begin
				r.status = release_blk(32'(d[28:17]));
			end
			if (r.status != ffba_pkg::ST_DONE) a = 0;
			r.addr = a[11:0];
			r.free_b = sat_bytes(free_u);
			r.used_b = sat_bytes(used_u);
			pending.push_back(r);
		endfunction

		function bit check_result(logic [47:0] d);
			heap_result_t e;
			bit bad;
			if (pending.size() == 0) begin
				$display("%0t unexpected result beat %h", $time, d);
				return 1;
			end
			e = pending.pop_front();
			bad = 0;
			if (d[1:0] !== e.status) begin
				$display("%0t status exp %0d got %0d", $time, e.status, d[1:0]);
				bad = 1;
			end
			if (d[13:2] !== e.addr) begin
				$display("%0t block_address exp %0d got %0d", $time, e.addr, d[13:2]);
				bad = 1;
			end
			if (d[29:14] !== e.free_b) begin
				$display("%0t free_bytes exp %0d got %0d", $time, e.free_b, d[29:14]);
				bad = 1;
			end
			if (d[45:30] !== e.used_b) begin
				$display("%0t used_bytes exp %0d got %0d", $time, e.used_b, d[45:30]);
				bad = 1;
			end
			return bad;
		endfunction
	endclass

	heap_scoreboard heap_sb;

	first_fit_block_allocator uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// result side: random stall, check each accepted beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (heap_sb.check_result(m_tdata)) failed = 1;
			end
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// one request beat, with random idle cycles before it
	task automatic send_beat(ffba_pkg::op_t op, logic [15:0] req, logic [11:0] rel);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, rel, req, op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		heap_sb.note_request(s_tdata);
	endtask

	task automatic send_alloc(logic [15:0] req);
		send_beat(ffba_pkg::OP_ALLOC, req, 12'd0);
	endtask

	task automatic send_release(logic [11:0] rel);
		send_beat(ffba_pkg::OP_RELEASE, 16'd0, rel);
	endtask

	// mostly small allocates, releases of live blocks, some noise
	task automatic random_phase(int n);
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(99);
			if (k < 40) begin
				if ($urandom_range(19) == 0) send_alloc(16'($urandom));
				else send_alloc(16'($urandom_range(600)));
			end else if (k < 85 && heap_sb.live.size() > 0) begin
				send_release(12'(heap_sb.live[$urandom_range(heap_sb.live.size() - 1)]));
			end else begin
				send_beat(ffba_pkg::op_t'($urandom_range(1)), 16'($urandom),
					12'($urandom));
			end
		end
	endtask

	initial begin
		heap_sb = new();
		failed = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		send_idle = 0;
		recv_idle = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero-byte, exact fits, splits, release cases, nothing fits
		send_release(12'd0);
		send_alloc(16'd0);
		send_alloc(16'd1);
		send_alloc(16'd16);
		send_alloc(16'd17);
		send_alloc(16'hffff);
		send_release(12'hfff);
		send_release(12'd5);
		send_release(12'(heap_sb.live[1]));
		send_release(12'(heap_sb.live[0]));
		send_release(12'(heap_sb.live[0]));
		send_alloc(16'd32);
		send_release(12'(heap_sb.live[heap_sb.live.size() - 1]));
		send_alloc(16'd40000);
		send_alloc(16'd25000);
		send_alloc(16'd2000);
		send_release(12'(heap_sb.live[0]));
		send_release(12'd1);
		send_beat(ffba_pkg::OP_RELEASE, 16'hffff, 12'hfff);
		send_beat(ffba_pkg::OP_ALLOC, 16'h5555, 12'haaa);

		send_idle = 14;
		recv_idle = 61;
		random_phase(480);
		send_idle = 61;
		recv_idle = 14;
		random_phase(480);
		send_idle = 0;
		recv_idle = 0;
		random_phase(470);
		s_tvalid <= 1'b0;

		n_left = 0;
		while (heap_sb.pending.size() != 0 && n_left < 200000) begin
			@(posedge clk);
			n_left++;
		end
		repeat (100) @(posedge clk);
		if (!failed && heap_sb.pending.size() == 0) begin
			$display("PASS first_fit_block_allocator");
		end else begin
			$display("FAIL first_fit_block_allocator");
		end
		$finish;
	end

	initial begin
		#1000000000;
		$display("FAIL first_fit_block_allocator");
		$finish;
	end
endmodule

[filelist.f]
sv/ffba_pkg.sv
sv/ffba_mem.sv
sv/ffba_div.sv
sv/first_fit_block_allocator.sv
sv/ffba_checker.sv
dv/tb_top.sv
